// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that check their own logic.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Clocked implication checked in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hw/rtl/upcd_pkg.sv -----
// Types, constants and byte-decision functions of the URI percent decoder.
// No dependencies.
package upcd_pkg;

  localparam int DEPTH   = 8;                      // result cells in the output chain
  localparam int MAX_RES = 4;                      // results one item can cause
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int NRES_W  = $clog2(MAX_RES + 1);
  localparam int PICK_W  = $clog2(MAX_RES);

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [3:0] NIB_MASK   = 4'hF;
  localparam logic [3:0] NIB_ALPHA  = 4'd9;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_BYTE,
    ACT_STOP
  } act_t;

  typedef struct packed {
    logic       run_last;
    logic       end_of_string;
    logic       has_byte;
    logic [7:0] out_byte;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_set_t;

  typedef struct packed {
    logic              shift;
    logic              load;
    logic [PICK_W-1:0] pick;
  } cell_ctrl_t;

  typedef struct packed {
    act_t       act;
    logic [1:0] used;
    logic [7:0] data;
    logic       past_host;
  } dec_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
  endfunction

  // Valid for hex digits only; letters carry bit 6.
  function automatic logic [3:0] nibble(input logic [7:0] c);
    return (c[3:0] & NIB_MASK) + (c[6] ? NIB_ALPHA : 4'd0);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) || (c == CH_SPACE) ||
           (c == CH_QUOTE) || (c == CH_DQUOTE) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  // Decide the head byte c0 with avail bytes known (1..3).
  function automatic dec_t decide(input logic [7:0] c0, input logic [7:0] c1,
                                  input logic [7:0] c2, input logic [1:0] avail,
                                  input logic ph);
    dec_t d;
    logic esc;
    d.act       = ACT_BYTE;
    d.used      = 2'd1;
    d.data      = lower(c0);
    d.past_host = ph;
    esc = (c0 == CH_PERCENT) || (!ph && (c0 == CH_EQUALS));
    if (esc && (avail == 2'd3) && is_hex(c1) && is_hex(c2)) begin
      d.data = lower({nibble(c1), nibble(c2)});
      d.used = 2'd3;
    end else begin
      if (!ph && ((c0 == CH_QUEST) || (c0 == CH_SLASH) || (c0 == CH_BSLASH))) begin
        d.past_host = 1'b1;
      end
      if ((avail >= 2'd2) && (c0 == CH_EQUALS) && (c1 == CH_LF)) begin
        d.act  = ACT_NONE;
        d.used = 2'd2;
        d.data = 8'd0;
      end else if ((avail == 2'd3) && (c0 == CH_EQUALS) && (c1 == CH_CR) &&
                   (c2 == CH_LF)) begin
        d.act  = ACT_NONE;
        d.used = 2'd3;
        d.data = 8'd0;
      end else if (is_delim(c0)) begin
        d.act  = ACT_STOP;
        d.data = 8'd0;
      end
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/upcd_front.sv -----
// Lookahead window and byte decisions: turns one input item into up to four results.
// Depends on upcd_pkg.
module upcd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 in_byte,
  input  logic                       is_last,
  input  logic                       accept,
  output upcd_pkg::res_set_t         results,
  output logic [upcd_pkg::NRES_W-1:0] nres,
  output logic                       stopped
);
  import upcd_pkg::*;

  logic [7:0] win0, win1;
  logic [1:0] win_count;
  logic       past_host;

  logic [7:0] win0_next, win1_next;
  logic [1:0] win_count_next;
  logic       past_host_next;
  logic       stopped_next;

  always_comb begin : decide_blk
    logic [7:0] bufx [5];
    logic [1:0] nwin, n, pos;
    logic       ph, ended, active;
    logic [2:0] k;
    dec_t       d;

    nwin = (win_count == 2'd3) ? 2'd2 : win_count;
    n    = nwin + 2'd1;
    bufx[0] = win0;
    bufx[1] = win1;
    bufx[2] = 8'd0;
    bufx[3] = 8'd0;
    bufx[4] = 8'd0;
    bufx[3'(nwin)] = in_byte;

    pos     = 2'd0;
    ph      = past_host;
    ended   = 1'b0;
    k       = 3'd0;
    results = '0;
    d       = '0;

    // Up to three dependent decisions; without the last flag only a full window decides.
    for (int s = 0; s < 3; s++) begin
      active = is_last ? (!ended && (pos < n)) : ((s == 0) && (n == 2'd3));
      if (active) begin
        d = decide(bufx[3'(pos)], bufx[3'(pos) + 3'd1], bufx[3'(pos) + 3'd2],
                   n - pos, ph);
        pos = pos + d.used;
        ph  = d.past_host;
        if (d.act == ACT_BYTE) begin
          results[k[PICK_W-1:0]].out_byte = d.data;
          results[k[PICK_W-1:0]].has_byte = 1'b1;
          k = k + 3'd1;
        end else if (d.act == ACT_STOP) begin
          results[k[PICK_W-1:0]].end_of_string = 1'b1;
          k = k + 3'd1;
          ended = 1'b1;
        end
      end
    end
    if (is_last && !ended) begin
      results[k[PICK_W-1:0]].end_of_string = 1'b1;
      k = k + 3'd1;
    end
    if (stopped) begin
      results = '0;
      k       = 3'd0;
    end
    if (k != 3'd0) begin
      results[PICK_W'(k - 3'd1)].run_last = 1'b1;
    end
    nres = NRES_W'(k);

    win0_next      = bufx[3'(pos)];
    win1_next      = bufx[3'(pos) + 3'd1];
    win_count_next = n - pos;
    past_host_next = ph;
    stopped_next   = stopped;
    if (stopped || is_last) begin
      win0_next      = 8'd0;
      win1_next      = 8'd0;
      win_count_next = 2'd0;
      past_host_next = 1'b0;
      stopped_next   = !is_last;
    end else if (ended) begin
      win0_next      = 8'd0;
      win1_next      = 8'd0;
      win_count_next = 2'd0;
      stopped_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0      <= 8'd0;
      win1      <= 8'd0;
      win_count <= 2'd0;
      past_host <= 1'b0;
      stopped   <= 1'b0;
    end else if (accept) begin
      win0      <= win0_next;
      win1      <= win1_next;
      win_count <= win_count_next;
      past_host <= past_host_next;
      stopped   <= stopped_next;
    end
  end

endmodule

// ----- hw/rtl/upcd_cell.sv -----
// One cell of the output chain: holds a result, shifts toward the head or loads a new one.
// Depends on upcd_pkg.
module upcd_cell (
  input  logic                 clk,
  input  upcd_pkg::res_t       up,
  input  upcd_pkg::res_set_t   results,
  input  upcd_pkg::cell_ctrl_t ctrl,
  output upcd_pkg::res_t       entry
);
  import upcd_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= results[ctrl.pick];
    end else if (ctrl.shift) begin
      entry <= up;
    end
  end

endmodule

// ----- hw/rtl/uri_percent_softbreak_decoder.sv -----
// Top level of the URI percent decoder with soft-break removal.
// Depends on upcd_pkg, upcd_front, upcd_cell and assert_macros.svh.
//
// Input channel s_*: one raw byte per item, s_tlast on the final byte of a text.
// Output channel m_*: one result per item: a decoded lower-cased byte (has_byte)
// or an end report (end_of_string); m_tlast marks the last result caused by
// one input item.
// A byte is decided once two more bytes have arrived, or at the last item, so a
// byte's result is loaded two items after the byte entered; a result is
// loaded into the output chain at the edge that accepts its item.
// Throughput is one item per cycle while s_tready is high: an ordinary item
// causes at most one result. A last item causes up to four results, drained one
// per cycle while m_tready is high from an eight-cell output chain; s_tready
// drops while more than four results wait. When m_tready is low the chain holds
// its results and fills until s_tready drops; nothing is lost.
// Reset (rst, synchronous) empties the window and the output chain and clears
// the host and stop flags.
`include "assert_macros.svh"
module uri_percent_softbreak_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // is_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] has_byte, [1] end_of_string
  output logic       m_tlast    // run_last
);
  import upcd_pkg::*;

  logic              accept, pop, stopped;
  res_set_t          results;
  logic [NRES_W-1:0] nres;
  logic [CNT_W-1:0]  count, count_next, base;
  res_t              q [DEPTH];
  cell_ctrl_t        ctrl [DEPTH];

  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (count <= CNT_W'(DEPTH - MAX_RES));
  assign base     = count - CNT_W'(pop);

  upcd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_byte (s_tdata),
    .is_last (s_tlast),
    .accept  (accept),
    .results (results),
    .nres    (nres),
    .stopped (stopped)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CNT_W-1:0] rel;
    res_t             up;
    assign rel = CNT_W'(i) - base;
    if (i == DEPTH - 1) begin : g_tail
      assign up = '0;
    end else begin : g_mid
      assign up = q[i+1];
    end
    always_comb begin
      ctrl[i].shift = pop;
      ctrl[i].load  = accept && (CNT_W'(i) >= base) && (rel < CNT_W'(nres));
      ctrl[i].pick  = rel[PICK_W-1:0];
    end
    upcd_cell u_cell (
      .clk     (clk),
      .up      (up),
      .results (results),
      .ctrl    (ctrl[i]),
      .entry   (q[i])
    );
  end

  assign count_next = base + (accept ? CNT_W'(nres) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign m_tdata    = q[0].out_byte;
  assign m_tuser[0] = q[0].has_byte;
  assign m_tuser[1] = q[0].end_of_string;
  assign m_tlast    = q[0].run_last;

  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH),
               "output chain overflow")
  `ASSERT_IMPL(a_end_is_final, clk, rst, m_tvalid && m_tuser[1], m_tlast && !m_tuser[0],
               "end report not the final result of its item")
  `ASSERT_NEXT(a_last_reports, clk, rst, accept && s_tlast && !stopped, m_tvalid,
               "last item left no result")

endmodule
